### hdl/cbpa_pkg.sv
// shared sizes, codes, state encoding and helpers for the chunked bitmap page allocator
// no dependencies
package cbpa_pkg;

  localparam int NUM_CHUNKS  = 4;
  localparam int MAP_WORDS   = 8;
  localparam int WORD_BITS   = 64;

  localparam int CHUNK_W     = $clog2(NUM_CHUNKS);
  localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS + 1);
  localparam int WIDX_W      = $clog2(MAP_WORDS);
  localparam int BIDX_W      = $clog2(WORD_BITS);
  localparam int OFF_W       = WIDX_W + BIDX_W;
  localparam int ADDR_W      = CHUNK_W + WIDX_W;
  localparam int MAP_DEPTH   = NUM_CHUNKS * MAP_WORDS;
  localparam int CAPACITY    = MAP_WORDS * WORD_BITS;

  localparam int FRAME_W     = 36;
  localparam int BASE_W      = FRAME_W + 1;
  localparam int PPC_W       = 10;
  localparam int CCNT_W      = 10;
  localparam int TOT_W       = 12;
  localparam int FUNC_W      = 2;
  localparam int COUNT_W     = 5;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_GRANT   = 16;
  localparam int GIDX_W      = $clog2(MAX_GRANT);
  localparam int CCNT_MAX    = 1023;
  localparam int TOT_MAX     = 4095;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_OUTSIDE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNKS = 2'd0,
    CFG_PAGES  = 2'd1,
    CFG_START  = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ACHK,
    S_CHUNK,
    S_LOAD,
    S_SCAN,
    S_FINISH,
    S_EMIT,
    S_FIND,
    S_FLOAD
  } state_t;

  typedef struct packed {
    logic                 clear;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } map_req_t;

  function automatic logic [BIDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [BIDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIDX_W'(i);
      end
    end
    return idx;
  endfunction

  // bits of word w whose page offset lies below ppc
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [WIDX_W-1:0] w,
                                                      input logic [PPC_W-1:0]  ppc);
    logic [PPC_W:0]       first;
    logic [PPC_W:0]       lim;
    logic [WORD_BITS-1:0] m;
    first = (PPC_W + 1)'(w) << BIDX_W;
    lim   = '0;
    if ({1'b0, ppc} <= first) begin
      m = '0;
    end else begin
      lim = {1'b0, ppc} - first;
      if (lim >= (PPC_W + 1)'(WORD_BITS)) begin
        m = '1;
      end else begin
        m = ~({WORD_BITS{1'b1}} << lim[BIDX_W-1:0]);
      end
    end
    return m;
  endfunction

endpackage

### hdl/chunked_bitmap_page_allocator_unit.sv
// chunked bitmap page allocator: init, query and free each give a single result word
// allocate: checks the free total, then walks the chunks, loading and scanning each map word
// and granting pages one at a time, then emits one word per grant, one word per cycle; a refusal
// before the scan or an empty scan gives a single NOSPACE word
// busy drops as the final word shows; the next item may be accepted as it shows
// reset (synchronous, rst_n low): config to 4 chunks, 512 pages, start 0; map all free
module chunked_bitmap_page_allocator_unit
  import cbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [COUNT_W-1:0]   in_page_count,
  input  logic [FRAME_W-1:0]   in_frame,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [FRAME_W-1:0]   out_granted_frame,
  output logic                 out_is_member,
  output logic                 out_last,
  output logic [TOT_W-1:0]     out_free_total,
  output logic [TOT_W-1:0]     out_used_total,
  output logic [TOT_W-1:0]     out_peak_used,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAME_W-1:0]   cfg_data
);

  state_t                 state_r, state_nxt;
  func_t                  func_r, func_nxt;
  logic [COUNT_W-1:0]     want_r, want_nxt;
  logic [FRAME_W-1:0]     frame_r, frame_nxt;
  logic [CHUNK_CNT_W-1:0] c_r, c_nxt;
  logic [WIDX_W-1:0]      w_r, w_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [COUNT_W-1:0]     n_r, n_nxt;
  logic [GIDX_W-1:0]      k_r, k_nxt;
  logic [WORD_BITS-1:0]   word_r, word_nxt;
  logic                   dirty_r, dirty_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [CCNT_W-1:0]      cnt_r [NUM_CHUNKS];
  logic [CCNT_W-1:0]      cnt_nxt [NUM_CHUNKS];
  logic [TOT_W-1:0]       tf_r, tf_nxt;
  logic [TOT_W-1:0]       tu_r, tu_nxt;
  logic [TOT_W-1:0]       pk_r, pk_nxt;
  logic [FRAME_W-1:0]     grant_r [MAX_GRANT];

  logic [2:0]             chunks_r;
  logic [PPC_W-1:0]       ppc_r;
  logic [FRAME_W-1:0]     start_frame_r;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [FRAME_W-1:0]     out_granted_r;
  logic                   out_member_r;
  logic                   out_last_r;
  logic [TOT_W-1:0]       out_free_r;
  logic [TOT_W-1:0]       out_used_r;
  logic [TOT_W-1:0]       out_peak_r;

  logic                   emit;
  status_t                emit_status;
  logic [FRAME_W-1:0]     emit_granted;
  logic                   emit_member;
  logic                   emit_last;
  logic                   grant_we;

  map_req_t               map_req;
  logic [WORD_BITS-1:0]   map_rdata;

  logic [CHUNK_CNT_W-1:0]         nch_eff;
  logic [PPC_W-1:0]               ppc_eff;
  logic [CHUNK_CNT_W+PPC_W-1:0]   init_total;
  logic [CHUNK_W-1:0]             c_idx;
  logic [WORD_BITS-1:0]           avail;
  logic [BIDX_W-1:0]              bit_sel;
  logic [FRAME_W-1:0]             grant_val;
  logic [PPC_W:0]                 next_word_off;
  logic [BASE_W:0]                diff;
  logic                           hit;
  logic [TOT_W:0]                 used_sum;
  logic [COUNT_W-1:0]             k_next_cnt;

  cbpa_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (map_req),
    .rdata (map_rdata)
  );

  assign nch_eff    = (chunks_r > CHUNK_CNT_W'(NUM_CHUNKS)) ? CHUNK_CNT_W'(NUM_CHUNKS)
                                                            : CHUNK_CNT_W'(chunks_r);
  assign ppc_eff    = (ppc_r > PPC_W'(CAPACITY)) ? PPC_W'(CAPACITY) : ppc_r;
  assign init_total = {{PPC_W{1'b0}}, nch_eff} * {{CHUNK_CNT_W{1'b0}}, ppc_eff};
  assign c_idx      = c_r[CHUNK_W-1:0];
  assign avail      = word_r & range_mask(w_r, ppc_eff);
  assign bit_sel    = lowest_bit(avail);
  assign grant_val  = FRAME_W'(base_r + BASE_W'({w_r, bit_sel}));
  assign next_word_off = ((PPC_W + 1)'(w_r) + (PPC_W + 1)'(1)) << BIDX_W;
  assign diff       = {2'b00, frame_r} - {1'b0, base_r};
  assign hit        = !diff[BASE_W] && (diff[BASE_W-1:0] < BASE_W'(ppc_eff));
  assign used_sum   = {1'b0, tu_r} + (TOT_W + 1)'(n_r);
  assign k_next_cnt = COUNT_W'(k_r) + COUNT_W'(1);

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    want_nxt  = want_r;
    frame_nxt = frame_r;
    c_nxt     = c_r;
    w_nxt     = w_r;
    base_nxt  = base_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    word_nxt  = word_r;
    dirty_nxt = dirty_r;
    off_nxt   = off_r;
    cnt_nxt   = cnt_r;
    tf_nxt    = tf_r;
    tu_nxt    = tu_r;
    pk_nxt    = pk_r;
    map_req   = '0;
    grant_we  = 1'b0;
    emit         = 1'b0;
    emit_status  = STS_OK;
    emit_granted = '0;
    emit_member  = 1'b0;
    emit_last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = func_t'(in_func);
          want_nxt  = (in_page_count > COUNT_W'(MAX_GRANT)) ? COUNT_W'(MAX_GRANT)
                                                            : in_page_count;
          frame_nxt = in_frame;
          c_nxt     = '0;
          base_nxt  = {1'b0, start_frame_r};
          n_nxt     = '0;
          k_nxt     = '0;
          unique case (func_t'(in_func))
            FN_INIT:           state_nxt = S_INIT;
            FN_ALLOC:          state_nxt = S_ACHK;
            FN_FREE, FN_QUERY: state_nxt = S_FIND;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end

      S_INIT: begin
        map_req.clear = 1'b1;
        for (int i = 0; i < NUM_CHUNKS; i++) begin
          cnt_nxt[i] = (CHUNK_CNT_W'(i) < nch_eff) ? CCNT_W'(ppc_eff) : '0;
        end
        tf_nxt    = TOT_W'(init_total);
        tu_nxt    = '0;
        pk_nxt    = '0;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end

      S_ACHK: begin
        if (TOT_W'(want_r) > tf_r) begin
          emit        = 1'b1;
          emit_status = STS_NOSPACE;
          state_nxt   = S_IDLE;
        end else if (want_r == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CHUNK;
        end
      end

      S_CHUNK: begin
        if ((c_r < nch_eff) && (n_r < want_r)) begin
          if ((cnt_r[c_idx] != '0) && (ppc_eff != '0)) begin
            w_nxt           = '0;
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = {c_idx, {WIDX_W{1'b0}}};
            state_nxt       = S_LOAD;
          end else begin
            c_nxt    = c_r + CHUNK_CNT_W'(1);
            base_nxt = base_r + BASE_W'(ppc_eff);
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_LOAD: begin
        word_nxt  = map_rdata;
        dirty_nxt = 1'b0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if ((n_r < want_r) && (cnt_r[c_idx] != '0) && (avail != '0)) begin
          grant_we       = 1'b1;
          word_nxt       = word_r & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel);
          dirty_nxt      = 1'b1;
          n_nxt          = n_r + COUNT_W'(1);
          cnt_nxt[c_idx] = cnt_r[c_idx] - CCNT_W'(1);
        end else begin
          if (dirty_r) begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = {c_idx, w_r};
            map_req.wr_data = word_r;
          end
          if ((n_r < want_r) && (cnt_r[c_idx] != '0) && (next_word_off < {1'b0, ppc_eff})) begin
            w_nxt           = w_r + WIDX_W'(1);
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = {c_idx, w_r + WIDX_W'(1)};
            state_nxt       = S_LOAD;
          end else begin
            c_nxt     = c_r + CHUNK_CNT_W'(1);
            base_nxt  = base_r + BASE_W'(ppc_eff);
            state_nxt = S_CHUNK;
          end
        end
      end

      S_FINISH: begin
        if (n_r == '0) begin
          emit        = 1'b1;
          emit_status = STS_NOSPACE;
          state_nxt   = S_IDLE;
        end else begin
          tf_nxt = (tf_r > TOT_W'(n_r)) ? tf_r - TOT_W'(n_r) : '0;
          tu_nxt = (used_sum > (TOT_W + 1)'(TOT_MAX)) ? TOT_W'(TOT_MAX)
                                                     : used_sum[TOT_W-1:0];
          pk_nxt = (tu_nxt > pk_r) ? tu_nxt : pk_r;
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        emit         = 1'b1;
        emit_granted = grant_r[k_r];
        emit_last    = (k_next_cnt == n_r);
        k_nxt        = k_r + GIDX_W'(1);
        if (k_next_cnt == n_r) begin
          state_nxt = S_IDLE;
        end
      end

      S_FIND: begin
        if (c_r < nch_eff) begin
          if (hit) begin
            if (func_r == FN_QUERY) begin
              emit        = 1'b1;
              emit_member = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              off_nxt         = diff[OFF_W-1:0];
              map_req.rd_en   = 1'b1;
              map_req.rd_addr = {c_idx, diff[OFF_W-1:BIDX_W]};
              state_nxt       = S_FLOAD;
            end
          end else begin
            c_nxt    = c_r + CHUNK_CNT_W'(1);
            base_nxt = base_r + BASE_W'(ppc_eff);
          end
        end else begin
          emit        = 1'b1;
          emit_status = (func_r == FN_QUERY) ? STS_OK : STS_OUTSIDE;
          state_nxt   = S_IDLE;
        end
      end

      S_FLOAD: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = {c_idx, off_r[OFF_W-1:BIDX_W]};
        map_req.wr_data = map_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << off_r[BIDX_W-1:0]);
        if (cnt_r[c_idx] < CCNT_W'(CCNT_MAX)) begin
          cnt_nxt[c_idx] = cnt_r[c_idx] + CCNT_W'(1);
        end
        if (tf_r < TOT_W'(TOT_MAX)) begin
          tf_nxt = tf_r + TOT_W'(1);
        end
        if (tu_r != '0) begin
          tu_nxt = tu_r - TOT_W'(1);
        end
        emit        = 1'b1;
        emit_member = 1'b1;
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        cnt_r[i] <= '0;
      end
      tf_r <= '0;
      tu_r <= '0;
      pk_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      cnt_r       <= cnt_nxt;
      tf_r        <= tf_nxt;
      tu_r        <= tu_nxt;
      pk_r        <= pk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    want_r  <= want_nxt;
    frame_r <= frame_nxt;
    c_r     <= c_nxt;
    w_r     <= w_nxt;
    base_r  <= base_nxt;
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    word_r  <= word_nxt;
    dirty_r <= dirty_nxt;
    off_r   <= off_nxt;
    if (grant_we) begin
      grant_r[n_r[GIDX_W-1:0]] <= grant_val;
    end
    out_status_r  <= emit_status;
    out_granted_r <= emit_granted;
    out_member_r  <= emit_member;
    out_last_r    <= emit_last;
    out_free_r    <= tf_nxt;
    out_used_r    <= tu_nxt;
    out_peak_r    <= pk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunks_r      <= 3'd4;
      ppc_r         <= PPC_W'(CAPACITY);
      start_frame_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CHUNKS: chunks_r      <= cfg_data[2:0];
        CFG_PAGES:  ppc_r         <= cfg_data[PPC_W-1:0];
        CFG_START:  start_frame_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_frame = out_granted_r;
  assign out_is_member     = out_member_r;
  assign out_last          = out_last_r;
  assign out_free_total    = out_free_r;
  assign out_used_total    = out_used_r;
  assign out_peak_used     = out_peak_r;

endmodule

### hdl/cbpa_map.sv
// free bitmap store: one word per chunk and map word, registered read
// words never written since reset or clear read as all free; uses cbpa_pkg
module cbpa_map
  import cbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  map_req_t             req,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] valid_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvalid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '1;

endmodule

### tb/tb_chunked_bitmap_page_allocator_unit.sv
// self-checking testbench for chunked_bitmap_page_allocator_unit: directed and random commands,
// with its own model of the chunk bitmaps and page counters predicting every result word
// depends on cbpa_pkg (hdl/cbpa_pkg.sv) and the unit under test
module tb_chunked_bitmap_page_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import cbpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam logic [FRAME_W-1:0] FRAME_TOP = {FRAME_W{1'b1}};
  localparam int SETTLE = 8;
  localparam int TAIL = 100;
  localparam int MAX_SHOWN = 200;

  typedef enum logic [1:0] {
    K_CMD,
    K_CFG,
    K_DRAIN
  } job_kind_t;

  typedef struct {
    job_kind_t            kind;
    func_t                func;
    logic [COUNT_W-1:0]   count;
    logic [FRAME_W-1:0]   frame;
    logic [CFG_IDX_W-1:0] idx;
    logic [FRAME_W-1:0]   data;
    bit                   steady;
  } job_t;

  typedef struct {
    status_t            status;
    logic [FRAME_W-1:0] granted;
    logic               member;
    logic               last;
    logic [TOT_W-1:0]   free_t;
    logic [TOT_W-1:0]   used_t;
    logic [TOT_W-1:0]   peak_t;
  } page_word_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [COUNT_W-1:0]   in_page_count = '0;
  logic [FRAME_W-1:0]   in_frame = '0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [FRAME_W-1:0]   out_granted_frame;
  logic                 out_is_member;
  logic                 out_last;
  logic [TOT_W-1:0]     out_free_total;
  logic [TOT_W-1:0]     out_used_total;
  logic [TOT_W-1:0]     out_peak_used;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAME_W-1:0]   cfg_data = '0;

  chunked_bitmap_page_allocator_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_page_count     (in_page_count),
    .in_frame          (in_frame),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_frame (out_granted_frame),
    .out_is_member     (out_is_member),
    .out_last          (out_last),
    .out_free_total    (out_free_total),
    .out_used_total    (out_used_total),
    .out_peak_used     (out_peak_used),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // allocator mirror
  logic [WORD_BITS-1:0] m_map [NUM_CHUNKS][MAP_WORDS];
  int unsigned          m_cnt [NUM_CHUNKS];
  int unsigned          m_free;
  int unsigned          m_used;
  int unsigned          m_peak;
  logic [2:0]           m_chunks;
  logic [PPC_W-1:0]     m_pages;
  logic [FRAME_W-1:0]   m_start;

  job_t       job_q[$];
  page_word_t due_words[$];
  page_word_t want_word;

  int  n_pred = 0;
  int  n_seen = 0;
  int  n_errors = 0;
  int  n_cfg = 0;
  int  func_hits [4] = '{0, 0, 0, 0};
  int  quiet = 0;
  bit  took;
  bit  go_cmd;
  bit  go_cfg;

  // stimulus side view of the layout
  int unsigned        g_nch;
  int unsigned        g_ppc;
  logic [FRAME_W-1:0] g_start;
  bit                 gen_steady = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_SHOWN) begin
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    end
  endtask

  function automatic logic [FRAME_W-1:0] rand36();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[FRAME_W-1:0];
  endfunction

  function automatic int unsigned eff_chunks();
    return (m_chunks > NUM_CHUNKS) ? NUM_CHUNKS : int'(m_chunks);
  endfunction

  function automatic int unsigned eff_pages();
    return (m_pages > CAPACITY) ? CAPACITY : int'(m_pages);
  endfunction

  function automatic logic [63:0] base_of(input int unsigned c);
    return 64'(m_start) + 64'(c) * 64'(eff_pages());
  endfunction

  function automatic int owner_chunk(input logic [FRAME_W-1:0] f);
    logic [63:0] b;
    int          hit;
    hit = -1;
    for (int unsigned c = 0; c < eff_chunks(); c++) begin
      b = base_of(c);
      if (hit < 0 && b <= 64'(f) && 64'(f) < b + 64'(eff_pages())) begin
        hit = int'(c);
      end
    end
    return hit;
  endfunction

  function automatic void add_word(input status_t s, input logic [FRAME_W-1:0] g,
                                   input logic mem, input logic lst);
    page_word_t w;
    w.status  = s;
    w.granted = g;
    w.member  = mem;
    w.last    = lst;
    w.free_t  = TOT_W'(m_free);
    w.used_t  = TOT_W'(m_used);
    w.peak_t  = TOT_W'(m_peak);
    due_words.push_back(w);
    n_pred++;
  endfunction

  function automatic void track_command(input job_t j);
    int unsigned        nch;
    int unsigned        ppc;
    int unsigned        want;
    int unsigned        n;
    int unsigned        off;
    int                 hit;
    logic [63:0]        b;
    logic [FRAME_W-1:0] grants[$];
    nch = eff_chunks();
    ppc = eff_pages();
    case (j.func)
      FN_INIT: begin
        foreach (m_map[c, w]) m_map[c][w] = '1;
        for (int unsigned c = 0; c < NUM_CHUNKS; c++) m_cnt[c] = (c < nch) ? ppc : 0;
        m_free = nch * ppc;
        m_used = 0;
        m_peak = 0;
        add_word(STS_OK, '0, 1'b0, 1'b1);
      end
      FN_ALLOC: begin
        want = j.count;
        if (want > MAX_GRANT) want = MAX_GRANT;
        if (m_free < want) begin
          add_word(STS_NOSPACE, '0, 1'b0, 1'b1);
        end else if (want == 0) begin
          add_word(STS_OK, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned c = 0; c < nch && grants.size() < want; c++) begin
            b = base_of(c);
            for (off = 0; off < ppc && grants.size() < want && m_cnt[c] != 0; off++) begin
              if (m_map[c][off / WORD_BITS][off % WORD_BITS]) begin
                m_map[c][off / WORD_BITS][off % WORD_BITS] = 1'b0;
                grants.push_back(FRAME_W'(b + 64'(off)));
                m_cnt[c]--;
              end
            end
          end
          n = grants.size();
          if (n == 0) begin
            add_word(STS_NOSPACE, '0, 1'b0, 1'b1);
          end else begin
            m_free = (m_free > n) ? m_free - n : 0;
            m_used = (m_used + n > TOT_MAX) ? TOT_MAX : m_used + n;
            if (m_used > m_peak) m_peak = m_used;
            foreach (grants[i]) add_word(STS_OK, grants[i], 1'b0, i == n - 1);
          end
        end
      end
      FN_FREE, FN_QUERY: begin
        hit = owner_chunk(j.frame);
        if (j.func == FN_QUERY) begin
          add_word(STS_OK, '0, hit >= 0, 1'b1);
        end else if (hit < 0) begin
          add_word(STS_OUTSIDE, '0, 1'b0, 1'b1);
        end else begin
          off = 32'(64'(j.frame) - base_of(hit));
          m_map[hit][(off / WORD_BITS) % MAP_WORDS][off % WORD_BITS] = 1'b1;
          if (m_cnt[hit] < CCNT_MAX) m_cnt[hit]++;
          if (m_free < TOT_MAX) m_free++;
          if (m_used > 0) m_used--;
          add_word(STS_OK, '0, 1'b1, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_cfg(input job_t j);
    case (j.idx)
      CFG_CHUNKS: m_chunks = j.data[2:0];
      CFG_PAGES:  m_pages = j.data[PPC_W-1:0];
      CFG_START:  m_start = j.data;
      default: ;
    endcase
  endfunction

  // driver: holds a word until busy is low, config writes only when fully idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      quiet     = 0;
    end else begin
      took = 0;
      if (start && !busy) begin
        track_command(job_q[0]);
        func_hits[job_q[0].func]++;
        took = 1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(job_q[0]);
        n_cfg++;
        took = 1;
      end
      if (took) void'(job_q.pop_front());
      if (!busy && !start && !cfg_valid && n_pred <= n_seen) quiet++;
      else quiet = 0;

      if (start && busy) begin
        start <= 1'b1;
      end else if (cfg_valid && !cfg_ready) begin
        cfg_valid <= 1'b1;
      end else begin
        go_cmd = 0;
        go_cfg = 0;
        if (job_q.size() != 0) begin
          case (job_q[0].kind)
            K_CMD:   go_cmd = job_q[0].steady || ($urandom_range(0, 99) >= 29);
            K_CFG:   go_cfg = (quiet >= SETTLE);
            K_DRAIN: if (n_pred <= n_seen) void'(job_q.pop_front());
            default: ;
          endcase
        end
        start     <= go_cmd;
        cfg_valid <= go_cfg;
        if (go_cmd) begin
          in_func       <= job_q[0].func;
          in_page_count <= job_q[0].count;
          in_frame      <= job_q[0].frame;
        end else begin
          in_func       <= FUNC_W'($urandom);
          in_page_count <= COUNT_W'($urandom);
          in_frame      <= rand36();
        end
        if (go_cfg) begin
          cfg_index <= job_q[0].idx;
          cfg_data  <= job_q[0].data;
        end else begin
          cfg_index <= CFG_IDX_W'($urandom);
          cfg_data  <= rand36();
        end
      end
    end
  end

  // monitor: every strobed word is checked against the oldest due word
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_words.size() == 0) begin
        report("word with nothing due", 64'(out_granted_frame), 64'(0));
      end else begin
        want_word = due_words.pop_front();
        if (out_status !== want_word.status)
          report("status", 64'(out_status), 64'(want_word.status));
        if (out_granted_frame !== want_word.granted)
          report("granted_frame", 64'(out_granted_frame), 64'(want_word.granted));
        if (out_is_member !== want_word.member)
          report("is_member", 64'(out_is_member), 64'(want_word.member));
        if (out_last !== want_word.last)
          report("last", 64'(out_last), 64'(want_word.last));
        if (out_free_total !== want_word.free_t)
          report("free_total", 64'(out_free_total), 64'(want_word.free_t));
        if (out_used_total !== want_word.used_t)
          report("used_total", 64'(out_used_total), 64'(want_word.used_t));
        if (out_peak_used !== want_word.peak_t)
          report("peak_used", 64'(out_peak_used), 64'(want_word.peak_t));
      end
      n_seen <= n_seen + 1;
    end
  end

  function automatic void put_cmd(input func_t f, input int unsigned cnt,
                                  input logic [FRAME_W-1:0] fr);
    job_t j;
    j.kind   = K_CMD;
    j.func   = f;
    j.count  = COUNT_W'(cnt);
    j.frame  = fr;
    j.idx    = '0;
    j.data   = '0;
    j.steady = gen_steady;
    job_q.push_back(j);
  endfunction

  function automatic void put_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FRAME_W-1:0] data);
    job_t j;
    j.kind   = K_CFG;
    j.func   = FN_INIT;
    j.count  = '0;
    j.frame  = '0;
    j.idx    = idx;
    j.data   = data;
    j.steady = 1'b0;
    job_q.push_back(j);
  endfunction

  function automatic void put_drain();
    job_t j;
    j.kind   = K_DRAIN;
    j.func   = FN_INIT;
    j.count  = '0;
    j.frame  = '0;
    j.idx    = '0;
    j.data   = '0;
    j.steady = 1'b0;
    job_q.push_back(j);
  endfunction

  // unused upper data bits carry junk half the time
  function automatic void set_layout(input int unsigned ch, input int unsigned pg,
                                     input logic [FRAME_W-1:0] st);
    logic [FRAME_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 1) ? rand36() : '0;
    put_cfg(CFG_CHUNKS, (junk & ~FRAME_W'(7)) | FRAME_W'(ch));
    junk = ($urandom_range(0, 1) == 1) ? rand36() : '0;
    put_cfg(CFG_PAGES, (junk & ~FRAME_W'(10'h3FF)) | FRAME_W'(pg));
    put_cfg(CFG_START, st);
    g_nch   = (ch > NUM_CHUNKS) ? NUM_CHUNKS : ch;
    g_ppc   = (pg > CAPACITY) ? CAPACITY : pg;
    g_start = st;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned span;
    int unsigned r;
    int unsigned c;
    span = g_nch * g_ppc;
    r    = $urandom_range(0, 99);
    if (r < 40 && span != 0) begin
      c = $urandom_range(0, g_nch - 1);
      return g_start + FRAME_W'(c * g_ppc) +
             FRAME_W'($urandom_range(0, ((g_ppc < 32) ? g_ppc : 32) - 1));
    end else if (r < 70 && span != 0) begin
      return g_start + FRAME_W'($urandom_range(0, span - 1));
    end else if (r < 88) begin
      case ($urandom_range(0, 3))
        0: return g_start - FRAME_W'(1);
        1: return g_start;
        2: return g_start + FRAME_W'(span) - FRAME_W'(1);
        default: return g_start + FRAME_W'(span);
      endcase
    end
    return rand36();
  endfunction

  function automatic void random_phase(input int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        put_cmd(FN_INIT, $urandom_range(0, 31), rand36());
      end else if (r < 45) begin
        r = $urandom_range(0, 9);
        put_cmd(FN_ALLOC, (r == 0) ? 0 : (r == 1) ? $urandom_range(17, 31) :
                $urandom_range(1, 16), rand36());
      end else if (r < 78) begin
        put_cmd(FN_FREE, $urandom_range(0, 31), pick_frame());
      end else begin
        put_cmd(FN_QUERY, $urandom_range(0, 31), pick_frame());
      end
      if ($urandom_range(0, 59) == 0) put_drain();
    end
  endfunction

  initial begin
    foreach (m_map[c, w]) m_map[c][w] = '1;
    foreach (m_cnt[c]) m_cnt[c] = 0;
    m_free   = 0;
    m_used   = 0;
    m_peak   = 0;
    m_chunks = 3'd4;
    m_pages  = PPC_W'(512);
    m_start  = '0;
    g_nch    = 4;
    g_ppc    = 512;
    g_start  = '0;

    // directed: commands before any init, then the reset layout
    put_cmd(FN_ALLOC, 1, '0);
    put_cmd(FN_FREE, 0, FRAME_W'(5));
    put_cmd(FN_QUERY, 0, '0);
    put_cmd(FN_QUERY, 0, FRAME_W'(2047));
    put_cmd(FN_QUERY, 0, FRAME_W'(2048));
    put_cmd(FN_INIT, 0, '0);
    put_cmd(FN_ALLOC, 0, '0);
    put_cmd(FN_ALLOC, 16, '0);
    put_cmd(FN_ALLOC, 31, FRAME_TOP);
    put_drain();
    put_cmd(FN_FREE, 0, FRAME_W'(3));
    put_cmd(FN_FREE, 0, FRAME_W'(3));
    put_cmd(FN_FREE, 0, FRAME_W'(2048));
    put_cmd(FN_FREE, 0, FRAME_TOP);
    put_cmd(FN_QUERY, 0, FRAME_TOP);
    put_cmd(FN_ALLOC, 5, '0);
    put_cmd(FN_ALLOC, 17, '0);
    put_cfg(CFG_NONE, rand36());
    // one page at the very top of the frame space, double free and short scans
    set_layout(1, 1, FRAME_TOP);
    put_cmd(FN_INIT, 0, '0);
    put_cmd(FN_ALLOC, 2, '0);
    put_cmd(FN_ALLOC, 1, '0);
    put_cmd(FN_ALLOC, 1, '0);
    put_cmd(FN_FREE, 0, FRAME_TOP);
    put_cmd(FN_FREE, 0, FRAME_TOP);
    put_cmd(FN_ALLOC, 2, '0);
    put_cmd(FN_ALLOC, 1, '0);

    set_layout(2, 40, FRAME_W'(1000));
    put_cmd(FN_INIT, 0, '0);
    random_phase(50);
    set_layout(7, 1023, FRAME_TOP - FRAME_W'(700));
    put_cmd(FN_INIT, 0, '0);
    random_phase(40);
    set_layout(3, 70, rand36());
    put_cmd(FN_INIT, 0, '0);
    gen_steady = 1;
    random_phase(70);
    gen_steady = 0;
    set_layout(0, 300, rand36());
    put_cmd(FN_INIT, 0, '0);
    random_phase(12);
    set_layout(4, 0, rand36());
    put_cmd(FN_INIT, 0, '0);
    random_phase(12);
    set_layout(4, 64, '0);
    put_cmd(FN_INIT, 0, '0);
    random_phase(40);
    // layout changes without a fresh init
    set_layout(4, 100, '0);
    random_phase(20);
    set_layout(2, 100, FRAME_W'(50));
    random_phase(20);
    set_layout(1, 512, rand36());
    put_cmd(FN_INIT, 0, '0);
    random_phase(50);
    for (int k = 0; k < 3; k++) begin
      set_layout($urandom_range(0, 7), $urandom_range(1, 130), rand36());
      put_cmd(FN_INIT, 0, '0);
      random_phase(25);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (job_q.size() != 0 || n_pred > n_seen) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (due_words.size() != 0) report("words never seen", 64'(due_words.size()), 64'(0));

    $display("run covered %0d init, %0d allocate, %0d free, %0d query commands",
             func_hits[FN_INIT], func_hits[FN_ALLOC], func_hits[FN_FREE], func_hits[FN_QUERY]);
    $display("  %0d result words compared, %0d register writes, %0d mismatches",
             n_seen, n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("tb_chunked_bitmap_page_allocator_unit: clean");
    end else begin
      $display("tb_chunked_bitmap_page_allocator_unit: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d commands pending", job_q.size());
    $display("tb_chunked_bitmap_page_allocator_unit: errors");
    $finish;
  end

endmodule
